// ===== rtl/arp_pkg.sv =====
// Package for the ARP inspection block: constants, payload structs, codes.
// No dependencies.
`default_nettype none
package arp_pkg;
	localparam int BINDING_DEPTH = 64;
	localparam int REQUEST_DEPTH = 64;
	localparam int COUNT_WIDTH = 16;
	localparam int BA_W = $clog2(BINDING_DEPTH);
	localparam int RA_W = $clog2(REQUEST_DEPTH);
	localparam int SCAN_W = ((BA_W > RA_W) ? BA_W : RA_W) + 1;
	localparam int ENTRY_W = 80;
	localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY = 16'd2;
	localparam logic [13:0] ETH_HDR_LEN = 14'd14;
	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] SPAM_RESET = 16'd5;

	localparam logic [1:0] FS_OK = 2'd0, FS_SHORT = 2'd1, FS_NOT_ARP = 2'd2;
	localparam logic [2:0] BV_NONE = 3'd0, BV_MATCH = 3'd1, BV_LEARN = 3'd2,
		BV_FULL = 3'd3, BV_SPOOF = 3'd4;
	localparam logic [2:0] HC_OK = 3'd0, HC_REQ_NB = 3'd1, HC_REP_B = 3'd2,
		HC_DST = 3'd3, HC_SRC = 3'd4;
	localparam logic [1:0] LS_NONE = 2'd0, LS_STORED = 2'd1, LS_FULL = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [13:0] frame_length;
		logic [15:0] eth_type;
		logic [47:0] eth_dest_mac;
		logic [47:0] eth_source_mac;
		logic [15:0] arp_opcode;
		logic [47:0] arp_sha;
		logic [31:0] arp_spa;
		logic [47:0] arp_tha;
		logic [31:0] arp_tpa;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  frame_status;
		logic [2:0]  binding_verdict;
		logic [2:0]  header_check;
		logic        sender_ip_invalid;
		logic [15:0] request_count;
		logic        request_spam;
		logic [1:0]  load_status;
	} out_word_t;
endpackage
`default_nettype wire

// ===== rtl/arp_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module arp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/arp_packet_inspection_top.sv =====
// ARP inspection top: binding table and request counter in RAMs, scanned
// one entry per cycle. Uses arp_pkg and arp_ram.
// Flow: preload WRITE, DONE; reject/other opcode BSCAN, DONE; reply BSCAN walk,
// WRITE on miss, DONE; request BSCAN, RSCAN, DONE (RAM walks: one entry per cycle).
// One word at a time; next word accepted the cycle after the result is taken.
// Reset clears fill levels, threshold (to 5) and control; RAMs are not cleared.
`default_nettype none
module arp_packet_inspection_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire arp_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output arp_pkg::out_word_t      out_data
);
	import arp_pkg::*;

	typedef enum logic [2:0] {IDLE, BSCAN, RSCAN, WRITE, DONE} state_t;
	state_t state_q;

	in_word_t  item_q;
	out_word_t res_q;
	logic [15:0] thr_q;
	logic [BA_W:0] bfill_q;
	logic [RA_W:0] rfill_q;
	logic [SCAN_W-1:0] idx_q;
	logic pend_q;

	logic b_we, r_we, c_we;
	logic [BA_W-1:0] b_waddr, b_raddr;
	logic [RA_W-1:0] r_waddr, r_raddr;
	logic [ENTRY_W-1:0] b_wdata, b_rdata, r_wdata, r_rdata;
	logic [COUNT_WIDTH-1:0] c_wdata, c_rdata;

	arp_ram #(.WIDTH(ENTRY_W), .DEPTH(BINDING_DEPTH)) u_bind (
		.clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));
	arp_ram #(.WIDTH(ENTRY_W), .DEPTH(REQUEST_DEPTH)) u_req (
		.clk, .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata));
	arp_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(REQUEST_DEPTH)) u_cnt (
		.clk, .we(c_we), .waddr(r_waddr), .wdata(c_wdata), .raddr(r_raddr), .rdata(c_rdata));

	logic accept, bfull, rfull, is_req, is_rep, rhit, bhit;
	logic [2:0] hc;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [15:0] cnt_rep;
	logic [SCAN_W-1:0] ridx_d;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != IDLE) || out_valid;
	assign out_data = res_q;
	assign bfull = (bfill_q == (BA_W+1)'(BINDING_DEPTH));
	assign rfull = (rfill_q >= (RA_W+1)'(REQUEST_DEPTH - 1));
	assign is_req = item_q.arp_opcode == OP_REQUEST;
	assign is_rep = item_q.arp_opcode == OP_REPLY;
	assign bhit = pend_q && b_rdata[79:48] == item_q.arp_spa;
	assign rhit = pend_q && r_rdata[79:48] == item_q.arp_tpa
		&& r_rdata[47:0] == item_q.arp_sha;
	assign cnt_inc = (c_rdata == {COUNT_WIDTH{1'b1}}) ? c_rdata
		: c_rdata + COUNT_WIDTH'(1);
	assign ridx_d = idx_q - SCAN_W'(1);

	always_comb begin
		if (COUNT_WIDTH > 16) cnt_rep = (cnt_inc > 16'hFFFF) ? 16'hFFFF : 16'(cnt_inc);
		else cnt_rep = 16'(cnt_inc);
	end

	always_comb begin
		if (item_q.eth_source_mac != item_q.arp_sha) hc = HC_SRC;
		else if (is_req) hc = (item_q.eth_dest_mac == MAC_BCAST) ? HC_OK : HC_REQ_NB;
		else if (is_rep && item_q.eth_dest_mac == MAC_BCAST) hc = HC_REP_B;
		else if (is_rep && item_q.eth_dest_mac != item_q.arp_tha) hc = HC_DST;
		else hc = HC_OK;
	end

	always_comb begin
		b_raddr = idx_q[BA_W-1:0];
		r_raddr = idx_q[RA_W-1:0];
		b_we = 1'b0;
		b_waddr = bfill_q[BA_W-1:0];
		b_wdata = {item_q.arp_spa, item_q.arp_sha};
		r_we = 1'b0;
		c_we = 1'b0;
		r_waddr = rfill_q[RA_W-1:0];
		r_wdata = {item_q.arp_tpa, item_q.arp_sha};
		c_wdata = COUNT_WIDTH'(1);
		case (state_q)
			WRITE: begin
				b_we = !bfull && (item_q.operation || is_rep);
			end
			RSCAN: begin
				if (rhit) begin
					c_we = 1'b1;
					r_waddr = ridx_d[RA_W-1:0];
					c_wdata = cnt_inc;
				end else if (idx_q >= SCAN_W'(rfill_q) && !rfull) begin
					r_we = 1'b1;
					c_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid <= 1'b0;
			item_q <= '0;
			res_q <= '0;
			thr_q <= SPAM_RESET;
			bfill_q <= '0;
			rfill_q <= '0;
			idx_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_data;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept) begin
						item_q <= in_data;
						res_q <= '0;
						idx_q <= '0;
						pend_q <= 1'b0;
						state_q <= in_data.operation ? WRITE : BSCAN;
					end
				end
				BSCAN: begin
					if (item_q.frame_length < ETH_HDR_LEN) begin
						res_q.frame_status <= FS_SHORT;
						state_q <= DONE;
					end else if (item_q.eth_type != ETHERTYPE_ARP) begin
						res_q.frame_status <= FS_NOT_ARP;
						state_q <= DONE;
					end else begin
						res_q.header_check <= hc;
						if (is_req) begin
							state_q <= RSCAN;
						end else if (!is_rep) begin
							state_q <= DONE;
						end else begin
							res_q.sender_ip_invalid <= (item_q.arp_spa == '1)
								|| (item_q.arp_spa == '0);
							if (bhit) begin
								res_q.binding_verdict <=
									(b_rdata[47:0] == item_q.arp_sha) ? BV_MATCH : BV_SPOOF;
								state_q <= DONE;
							end else if (idx_q >= SCAN_W'(bfill_q)) begin
								state_q <= WRITE;
							end else begin
								pend_q <= 1'b1;
								idx_q <= idx_q + SCAN_W'(1);
							end
						end
					end
				end
				RSCAN: begin
					if (rhit) begin
						res_q.request_count <= cnt_rep;
						res_q.request_spam <= (32'(cnt_inc) >= 32'(thr_q));
						state_q <= DONE;
					end else if (idx_q >= SCAN_W'(rfill_q)) begin
						if (!rfull) begin
							rfill_q <= rfill_q + (RA_W+1)'(1);
							res_q.request_count <= 16'd1;
							res_q.request_spam <= (thr_q <= 16'd1);
						end
						state_q <= DONE;
					end else begin
						pend_q <= 1'b1;
						idx_q <= idx_q + SCAN_W'(1);
					end
				end
				WRITE: begin
					if (item_q.operation) begin
						res_q.load_status <= bfull ? LS_FULL : LS_STORED;
					end else begin
						res_q.binding_verdict <= bfull ? BV_FULL : BV_LEARN;
					end
					if (!bfull) bfill_q <= bfill_q + (BA_W+1)'(1);
					state_q <= DONE;
				end
				DONE: begin
					out_valid <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != IDLE) |-> !accept) else $error("accept while busy");
	a_bfill_range: assert property (@(posedge clk) disable iff (!arst_n)
		bfill_q <= (BA_W+1)'(BINDING_DEPTH)) else $error("binding fill overflow");
	a_rfill_range: assert property (@(posedge clk) disable iff (!arst_n)
		rfill_q <= (RA_W+1)'(REQUEST_DEPTH - 1)) else $error("request fill overflow");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DONE) |=> out_valid) else $error("result not presented");
`endif
endmodule
`default_nettype wire
